>>> rtl/core/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types, field widths and constants of the pack voltage monitor.
// ----------------------------------------------------------------------------
package pvm_pkg;

	localparam int NOW_W    = 32;
	localparam int MV_W     = 12;
	localparam int EXT_W    = 24;
	localparam int VOLT_W   = 22;
	localparam int RATIO_W  = 24;
	localparam int ALPHA_W  = 17;
	localparam int INTV_W   = 16;
	localparam int FRAC_W   = 16;

	localparam int PROD1_W  = MV_W + RATIO_W;
	localparam int PROD2_W  = PROD1_W + RATIO_W;
	localparam int NUM_W    = PROD2_W - FRAC_W;
	localparam int QUOT_W   = 34;
	localparam int REM_W    = 10;
	localparam int SUM_W    = QUOT_W + 2;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 4;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam int VOLT_MAX   = 3932160;
	localparam int ADC_MV_MAX = 3300;
	localparam int MV_PER_V   = 1000;
	localparam int Q16_ONE    = 65536;
	localparam int ROUND_BIAS = (MV_PER_V * Q16_ONE) / 2;

	localparam logic [2:0] REG_SOURCE_SELECT = 3'd0;
	localparam logic [2:0] REG_PIN_ASSIGNED  = 3'd1;
	localparam logic [2:0] REG_DIVIDER_RATIO = 3'd2;
	localparam logic [2:0] REG_CAL_GAIN      = 3'd3;
	localparam logic [2:0] REG_CAL_OFFSET    = 3'd4;
	localparam logic [2:0] REG_SMOOTH_ALPHA  = 3'd5;
	localparam logic [2:0] REG_INTERVAL_MS   = 3'd6;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOT_CFG = 2'd1,
		STS_ADC_INV = 2'd2,
		STS_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic                      source_select;
		logic                      pin_assigned;
		logic [RATIO_W-1:0]        divider_ratio;
		logic [RATIO_W-1:0]        cal_gain;
		logic signed [EXT_W-1:0]   cal_offset;
		logic [ALPHA_W-1:0]        smooth_alpha;
		logic [INTV_W-1:0]         interval_ms;
	} cfg_t;

endpackage

>>> rtl/core/pvm_regs.sv
// ----------------------------------------------------------------------------
// pvm_regs
// APB configuration registers of the pack voltage monitor.
// ----------------------------------------------------------------------------
module pvm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pvm_pkg::APB_AW-1:0]    paddr,
	input  logic [pvm_pkg::APB_DW-1:0]    pwdata,
	output logic [pvm_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output pvm_pkg::cfg_t                 cfg
);
	import pvm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[APB_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_select <= 1'b0;
			cfg_q.pin_assigned  <= 1'b0;
			cfg_q.divider_ratio <= RATIO_W'(Q16_ONE);
			cfg_q.cal_gain      <= RATIO_W'(Q16_ONE);
			cfg_q.cal_offset    <= '0;
			cfg_q.smooth_alpha  <= ALPHA_W'(6554);
			cfg_q.interval_ms   <= INTV_W'(1000);
		end else if (wr_en) begin
			unique case (idx)
				REG_SOURCE_SELECT: cfg_q.source_select <= pwdata[0];
				REG_PIN_ASSIGNED:  cfg_q.pin_assigned  <= pwdata[0];
				REG_DIVIDER_RATIO: cfg_q.divider_ratio <= pwdata[RATIO_W-1:0];
				REG_CAL_GAIN:      cfg_q.cal_gain      <= pwdata[RATIO_W-1:0];
				REG_CAL_OFFSET:    cfg_q.cal_offset    <= pwdata[EXT_W-1:0];
				REG_SMOOTH_ALPHA:  cfg_q.smooth_alpha  <= pwdata[ALPHA_W-1:0];
				REG_INTERVAL_MS:   cfg_q.interval_ms   <= pwdata[INTV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SOURCE_SELECT: prdata = APB_DW'(cfg_q.source_select);
			REG_PIN_ASSIGNED:  prdata = APB_DW'(cfg_q.pin_assigned);
			REG_DIVIDER_RATIO: prdata = APB_DW'(cfg_q.divider_ratio);
			REG_CAL_GAIN:      prdata = APB_DW'(cfg_q.cal_gain);
			REG_CAL_OFFSET:    prdata = APB_DW'(cfg_q.cal_offset);
			REG_SMOOTH_ALPHA:  prdata = APB_DW'(cfg_q.smooth_alpha);
			REG_INTERVAL_MS:   prdata = APB_DW'(cfg_q.interval_ms);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/pvm_scale.sv
// ----------------------------------------------------------------------------
// pvm_scale
// Bit-serial ADC scaling: mv * divider * gain, rounded, divided by 1000 * 2^16.
// ----------------------------------------------------------------------------
module pvm_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pvm_pkg::MV_W-1:0]      mv,
	input  logic [pvm_pkg::RATIO_W-1:0]   divider,
	input  logic [pvm_pkg::RATIO_W-1:0]   gain,
	output logic                          done,
	output logic [pvm_pkg::QUOT_W-1:0]    quot
);
	import pvm_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_MUL1,
		P_MUL2,
		P_ROUND,
		P_DIV
	} phase_t;

	phase_t               phase_q;
	logic [5:0]           cnt_q;
	logic [MV_W-1:0]      mv_q;
	logic [RATIO_W-1:0]   div_q;
	logic [RATIO_W-1:0]   gain_q;
	logic [PROD1_W-1:0]   prod1_q;
	logic [PROD2_W-1:0]   prod2_q;
	logic [NUM_W-1:0]     num_q;
	logic [REM_W-1:0]     rem_q;
	logic                 done_q;

	logic [REM_W:0]       trial;
	logic                 trial_ge;
	logic [REM_W:0]       trial_sub;
	logic [PROD2_W-1:0]   rounded;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_ge  = trial >= (REM_W+1)'(MV_PER_V);
	assign trial_sub = trial - (REM_W+1)'(MV_PER_V);
	assign rounded   = prod2_q + PROD2_W'(ROUND_BIAS);
	assign done      = done_q;
	assign quot      = num_q[QUOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			mv_q    <= '0;
			div_q   <= '0;
			gain_q  <= '0;
			prod1_q <= '0;
			prod2_q <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						mv_q    <= mv;
						div_q   <= divider;
						gain_q  <= gain;
						prod1_q <= '0;
						cnt_q   <= 6'(MV_W - 1);
						phase_q <= P_MUL1;
					end
				end
				P_MUL1: begin
					prod1_q <= {prod1_q[PROD1_W-2:0], 1'b0}
						+ (mv_q[MV_W-1] ? PROD1_W'(div_q) : '0);
					mv_q <= {mv_q[MV_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						prod2_q <= '0;
						cnt_q   <= 6'(RATIO_W - 1);
						phase_q <= P_MUL2;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				P_MUL2: begin
					prod2_q <= {prod2_q[PROD2_W-2:0], 1'b0}
						+ (gain_q[RATIO_W-1] ? PROD2_W'(prod1_q) : '0);
					gain_q <= {gain_q[RATIO_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						phase_q <= P_ROUND;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				P_ROUND: begin
					num_q   <= rounded[PROD2_W-1:FRAC_W];
					rem_q   <= '0;
					cnt_q   <= 6'(NUM_W - 1);
					phase_q <= P_DIV;
				end
				P_DIV: begin
					rem_q <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
					num_q <= {num_q[NUM_W-2:0], trial_ge};
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/pvm_ema.sv
// ----------------------------------------------------------------------------
// pvm_ema
// Bit-serial EMA update: (ema * 2^16 + alpha * (v - ema) + 2^15) >> 16.
// ----------------------------------------------------------------------------
module pvm_ema (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pvm_pkg::VOLT_W-1:0]    ema,
	input  logic [pvm_pkg::VOLT_W-1:0]    sample,
	input  logic [pvm_pkg::ALPHA_W-1:0]   alpha,
	output logic                          done,
	output logic [pvm_pkg::VOLT_W-1:0]    result
);
	import pvm_pkg::*;

	localparam int DIFF_W = VOLT_W + 1;
	localparam int ACC_W  = VOLT_W + FRAC_W + 2;

	typedef enum logic [1:0] {
		E_IDLE,
		E_MUL,
		E_FIN
	} ema_state_t;

	ema_state_t                 state_q;
	logic [4:0]                 cnt_q;
	logic [ALPHA_W-1:0]         a_q;
	logic signed [DIFF_W-1:0]   d_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [VOLT_W-1:0]          e_q;
	logic                       done_q;
	logic [VOLT_W-1:0]          result_q;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [ACC_W-1:0]    total;

	assign diff   = $signed({1'b0, sample}) - $signed({1'b0, ema});
	assign total  = $signed({2'b00, e_q, {FRAC_W{1'b0}}}) + acc_q
		+ $signed(ACC_W'(Q16_ONE / 2));
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= '0;
			a_q      <= '0;
			d_q      <= '0;
			acc_q    <= '0;
			e_q      <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						a_q     <= alpha;
						d_q     <= diff;
						e_q     <= ema;
						acc_q   <= '0;
						cnt_q   <= 5'(ALPHA_W - 1);
						state_q <= E_MUL;
					end
				end
				E_MUL: begin
					acc_q <= (acc_q <<< 1)
						+ (a_q[ALPHA_W-1] ? ACC_W'(d_q) : '0);
					a_q <= {a_q[ALPHA_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= E_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				E_FIN: begin
					result_q <= total[VOLT_W+FRAC_W-1:FRAC_W];
					done_q   <= 1'b1;
					state_q  <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/pack_voltage_ema_monitor.sv
// ----------------------------------------------------------------------------
// pack_voltage_ema_monitor
// Interval-gated pack voltage sampler with calibration and EMA smoothing.
//
//   Port group   Dir  Content (low bit first)
//   s_*          in   tdata: now_ms[31:0], adc_millivolts[43:32],
//                     ext_voltage[67:44]; tuser: ext_ok[0]
//   m_*          out  tdata: filtered_voltage[21:0]; tuser: voltage_valid[0],
//                     status_code[2:1], sample_taken[3]
//   APB          in   registers at byte address 4*index, index 0..6
//
// One request at a time. A tick that takes no sample or fails its checks before scaling
// goes from S_DECIDE straight to S_OUT. An external sample goes on to S_GOOD; an ADC sample
// first passes the bit-serial multipliers (12 + 24 steps), the 44-step divide by 1000 and
// the range check in S_CHECK. A good sample seeds the EMA or, once seeded, runs the 17-step
// EMA multiply; S_OUT then raises m_tvalid once any earlier result has been taken.
// s_tready is high only while idle; a waiting result does not block accept.
// Reset is asynchronous and returns all state and configuration to their reset values.
// ----------------------------------------------------------------------------
module pack_voltage_ema_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pvm_pkg::S_TDATA_W-1:0]   s_tdata,   // now_ms, adc_millivolts, ext_voltage
	input  logic [pvm_pkg::S_TUSER_W-1:0]   s_tuser,   // ext_ok
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pvm_pkg::M_TDATA_W-1:0]   m_tdata,   // filtered_voltage
	output logic [pvm_pkg::M_TUSER_W-1:0]   m_tuser,   // voltage_valid, status_code, sample_taken
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pvm_pkg::APB_AW-1:0]      paddr,
	input  logic [pvm_pkg::APB_DW-1:0]      pwdata,
	output logic [pvm_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);
	import pvm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCALE,
		S_CHECK,
		S_GOOD,
		S_EMA,
		S_OUT
	} state_t;

	cfg_t                    cfg;
	state_t                  state_q;
	logic [NOW_W-1:0]        now_q;
	logic [MV_W-1:0]         mv_q;
	logic signed [EXT_W-1:0] ext_q;
	logic                    ext_ok_q;
	logic [VOLT_W-1:0]       ema_q;
	logic                    seeded_q;
	logic [NOW_W-1:0]        last_q;
	logic [VOLT_W-1:0]       held_q;
	logic                    held_valid_q;
	status_t                 status_q;
	logic                    sampled_q;
	logic [VOLT_W-1:0]       v_q;
	logic                    scale_start_q;
	logic                    ema_start_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [M_TUSER_W-1:0]    m_tuser_q;

	logic                    avail;
	logic [NOW_W-1:0]        elapsed;
	logic                    due;
	logic                    ext_bad;
	logic                    mv_bad;
	logic                    scale_done;
	logic [QUOT_W-1:0]       quot;
	logic signed [SUM_W-1:0] v_full;
	logic                    v_bad;
	logic [ALPHA_W-1:0]      alpha_sat;
	logic                    ema_done;
	logic [VOLT_W-1:0]       ema_res;

	pvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pvm_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scale_start_q),
		.mv      (mv_q),
		.divider (cfg.divider_ratio),
		.gain    (cfg.cal_gain),
		.done    (scale_done),
		.quot    (quot)
	);

	pvm_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ema_start_q),
		.ema    (ema_q),
		.sample (v_q),
		.alpha  (alpha_sat),
		.done   (ema_done),
		.result (ema_res)
	);

	assign avail     = !cfg.source_select || cfg.pin_assigned;
	assign elapsed   = now_q - last_q;
	assign due       = elapsed >= NOW_W'(cfg.interval_ms);
	assign ext_bad   = !ext_ok_q || ext_q[EXT_W-1]
		|| (ext_q > $signed(EXT_W'(VOLT_MAX)));
	assign mv_bad    = (mv_q == '0) || (mv_q > MV_W'(ADC_MV_MAX));
	assign v_full    = $signed({2'b00, quot}) + SUM_W'(cfg.cal_offset);
	assign v_bad     = v_full[SUM_W-1] || (v_full > $signed(SUM_W'(VOLT_MAX)));
	assign alpha_sat = (cfg.smooth_alpha > ALPHA_W'(Q16_ONE))
		? ALPHA_W'(Q16_ONE) : cfg.smooth_alpha;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			now_q         <= '0;
			mv_q          <= '0;
			ext_q         <= '0;
			ext_ok_q      <= 1'b0;
			ema_q         <= '0;
			seeded_q      <= 1'b0;
			last_q        <= '0;
			held_q        <= '0;
			held_valid_q  <= 1'b0;
			status_q      <= STS_NOT_CFG;
			sampled_q     <= 1'b0;
			v_q           <= '0;
			scale_start_q <= 1'b0;
			ema_start_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			scale_start_q <= 1'b0;
			ema_start_q   <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						now_q    <= s_tdata[NOW_W-1:0];
						mv_q     <= s_tdata[NOW_W+MV_W-1:NOW_W];
						ext_q    <= s_tdata[NOW_W+MV_W+EXT_W-1:NOW_W+MV_W];
						ext_ok_q <= s_tuser[0];
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					sampled_q <= 1'b0;
					state_q   <= S_OUT;
					if (!avail) begin
						status_q <= STS_NOT_CFG;
					end else if (due) begin
						sampled_q <= 1'b1;
						last_q    <= now_q;
						if (!cfg.source_select) begin
							if (ext_bad) begin
								status_q     <= STS_ADC_INV;
								held_valid_q <= 1'b0;
								held_q       <= '0;
							end else begin
								v_q     <= ext_q[VOLT_W-1:0];
								state_q <= S_GOOD;
							end
						end else if (mv_bad) begin
							status_q <= STS_ADC_INV;
						end else begin
							scale_start_q <= 1'b1;
							state_q       <= S_SCALE;
						end
					end
				end
				S_SCALE: begin
					if (scale_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (v_bad) begin
						status_q <= STS_RANGE;
						state_q  <= S_OUT;
					end else begin
						v_q     <= v_full[VOLT_W-1:0];
						state_q <= S_GOOD;
					end
				end
				S_GOOD: begin
					if (!seeded_q) begin
						ema_q        <= v_q;
						seeded_q     <= 1'b1;
						held_q       <= v_q;
						held_valid_q <= 1'b1;
						status_q     <= STS_OK;
						state_q      <= S_OUT;
					end else begin
						ema_start_q <= 1'b1;
						state_q     <= S_EMA;
					end
				end
				S_EMA: begin
					if (ema_done) begin
						ema_q        <= ema_res;
						held_q       <= ema_res;
						held_valid_q <= 1'b1;
						status_q     <= STS_OK;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'(held_valid_q ? held_q : '0);
						m_tuser_q  <= {sampled_q, status_q, held_valid_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_invalid_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[VOLT_W-1:0] == '0)
		else $error("filtered voltage nonzero while not valid");

	a_ok_means_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:1] == STS_OK) |-> m_tuser[0])
		else $error("status ok without valid voltage");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_seed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("EMA seed lost");

	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= VOLT_W'(VOLT_MAX))
		else $error("held voltage above full scale");

endmodule
